@@ hw/rtl/lsps_pkg.sv @@
// shared types, constants and helpers of the light sensor percent scaler
`timescale 1ns / 1ps

package lsps_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned PctW    = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QuoW    = 7;
  localparam int unsigned DvdW    = 17;

  localparam logic [SampleW-1:0] FullScale  = 10'd1023;
  localparam logic [SampleW-1:0] ZeroSample = 10'd0;
  localparam logic [PctW-1:0]    PercentMax = 7'd100;
  localparam logic [PctW-1:0]    PercentMin = 7'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INVERT     = 3'd0,
    CFG_AUTOSCALE  = 3'd1,
    CFG_HYSTERESIS = 3'd2,
    CFG_RANGE_LOW  = 3'd3,
    CFG_RANGE_HIGH = 3'd4,
    CFG_PCT_FLOOR  = 3'd5,
    CFG_PCT_CEIL   = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_SCALE,
    ST_DIV,
    ST_FIN
  } seq_state_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [PctW-1:0]    percent;
    logic               accepted;
    logic               lower_widened;
    logic               upper_widened;
    logic [SampleW-1:0] bound_low;
    logic [SampleW-1:0] bound_high;
  } out_item_t;

  typedef struct packed {
    logic               invert;
    logic               autoscale;
    logic [SampleW-1:0] hysteresis;
    logic [PctW-1:0]    pct_floor;
    logic [PctW-1:0]    pct_ceil;
  } cfg_t;

  typedef struct packed {
    logic               low_we;
    logic               high_we;
    logic [SampleW-1:0] value;
  } bound_load_t;

  typedef struct packed {
    logic               start;
    logic [DvdW-1:0]    dividend;
    logic [SampleW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [PctW-1:0] sat_pct(input logic [PctW-1:0] v);
    sat_pct = (v > PercentMax) ? PercentMax : v;
  endfunction

endpackage

@@ hw/rtl/lsps_stream_if.sv @@
// valid/ready stream channel carrying one item
`timescale 1ns / 1ps

interface lsps_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/lsps_cfg_regs.sv @@
// configuration register file and tracked bound load decode
`timescale 1ns / 1ps

module lsps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lsps_pkg::SampleW-1:0]  cfg_data_i,
  output lsps_pkg::cfg_t                cfg_o,
  output lsps_pkg::bound_load_t         bload_o
);

  lsps_pkg::cfg_t cfg_q, cfg_d;
  logic           low_we, high_we;

  always_comb begin
    cfg_d   = cfg_q;
    low_we  = 1'b0;
    high_we = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsps_pkg::CFG_INVERT:     cfg_d.invert     = cfg_data_i[0];
        lsps_pkg::CFG_AUTOSCALE:  cfg_d.autoscale  = cfg_data_i[0];
        lsps_pkg::CFG_HYSTERESIS: cfg_d.hysteresis = cfg_data_i;
        lsps_pkg::CFG_RANGE_LOW:  low_we           = 1'b1;
        lsps_pkg::CFG_RANGE_HIGH: high_we          = 1'b1;
        lsps_pkg::CFG_PCT_FLOOR:  cfg_d.pct_floor  = cfg_data_i[lsps_pkg::PctW-1:0];
        lsps_pkg::CFG_PCT_CEIL:   cfg_d.pct_ceil   = cfg_data_i[lsps_pkg::PctW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invert     <= 1'b0;
      cfg_q.autoscale  <= 1'b1;
      cfg_q.hysteresis <= 10'd10;
      cfg_q.pct_floor  <= lsps_pkg::PercentMin;
      cfg_q.pct_ceil   <= lsps_pkg::PercentMax;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o           = cfg_q;
  assign bload_o.low_we  = low_we;
  assign bload_o.high_we = high_we;
  assign bload_o.value   = cfg_data_i;

endmodule

@@ hw/rtl/lsps_divider.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lsps_divider (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsps_pkg::div_req_t   req_i,
  output lsps_pkg::div_rsp_t   rsp_o
);

  localparam int unsigned DvsW = lsps_pkg::SampleW + lsps_pkg::QuoW - 1;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [2:0]                    cnt_q, cnt_d;
  logic [lsps_pkg::DvdW-1:0]     rem_q, rem_d;
  logic [DvsW-1:0]               dvs_q, dvs_d;
  logic [lsps_pkg::QuoW-1:0]     quo_q, quo_d;
  logic [lsps_pkg::DvdW-1:0]     dvs_ext;
  logic                          ge;

  assign dvs_ext = {{(lsps_pkg::DvdW-DvsW){1'b0}}, dvs_q};
  assign ge      = rem_q >= dvs_ext;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 3'(lsps_pkg::QuoW - 1);
      rem_d  = req_i.dividend;
      dvs_d  = {req_i.divisor, {(lsps_pkg::QuoW-1){1'b0}}};
      quo_d  = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dvs_ext;
      end
      quo_d = {quo_q[lsps_pkg::QuoW-2:0], ge};
      dvs_d = dvs_q >> 1;
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ hw/rtl/lsps_seq.sv @@
// sequencer with hysteresis test, bound tracking, limits and result register
`timescale 1ns / 1ps

module lsps_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsps_pkg::cfg_t                cfg_i,
  input  lsps_pkg::bound_load_t         bload_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lsps_pkg::SampleW-1:0]  in_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lsps_pkg::out_item_t           out_item_o,
  output lsps_pkg::div_req_t            div_req_o,
  input  lsps_pkg::div_rsp_t            div_rsp_i
);

  localparam int unsigned W = lsps_pkg::SampleW;
  localparam int unsigned P = lsps_pkg::PctW;

  lsps_pkg::seq_state_e state_q, state_d;

  logic [W-1:0] smp_q, last_q, last_d, tl_q, tl_d, th_q, th_d, v_q, v_d;
  logic [P-1:0] held_q, held_d, m_q, m_d;
  logic         take_q, lw_q, uw_q;
  logic         out_valid_q, out_valid_d;
  lsps_pkg::out_item_t out_q, out_d;

  logic         accept, do_test, do_scale, div_start, fin_load, out_free;
  logic [W-1:0] hyst_lo, num, den;
  logic [W:0]   hyst_hi;
  logic         take_c, lw_c, uw_c, range_ok;
  logic [lsps_pkg::DvdW-1:0] dividend;
  logic [P-1:0] fl, ce, pct_c;

  assign out_free = !out_valid_q || out_ready_i;
  assign range_ok = tl_q < th_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsps_pkg::ST_IDLE:  if (in_valid_i) state_d = lsps_pkg::ST_TEST;
      lsps_pkg::ST_TEST:  state_d = take_c ? lsps_pkg::ST_SCALE : lsps_pkg::ST_FIN;
      lsps_pkg::ST_SCALE: state_d = range_ok ? lsps_pkg::ST_DIV : lsps_pkg::ST_FIN;
      lsps_pkg::ST_DIV:   if (div_rsp_i.done) state_d = lsps_pkg::ST_FIN;
      lsps_pkg::ST_FIN:   if (out_free) state_d = lsps_pkg::ST_IDLE;
      default:            state_d = lsps_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    accept     = 1'b0;
    do_test    = 1'b0;
    do_scale   = 1'b0;
    div_start  = 1'b0;
    fin_load   = 1'b0;
    unique case (state_q)
      lsps_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
      end
      lsps_pkg::ST_TEST:  do_test = 1'b1;
      lsps_pkg::ST_SCALE: begin
        do_scale  = 1'b1;
        div_start = range_ok;
      end
      lsps_pkg::ST_DIV:   ;
      lsps_pkg::ST_FIN:   fin_load = out_free;
      default: ;
    endcase
  end

  // hysteresis window and bound tracking
  always_comb begin
    hyst_lo = (last_q > cfg_i.hysteresis) ? last_q - cfg_i.hysteresis : lsps_pkg::ZeroSample;
    hyst_hi = {1'b0, last_q} + {1'b0, cfg_i.hysteresis};
    take_c  = (smp_q != last_q) &&
              (smp_q == lsps_pkg::ZeroSample || smp_q == lsps_pkg::FullScale ||
               {1'b0, smp_q} > hyst_hi || smp_q < hyst_lo);
    lw_c    = cfg_i.autoscale && (smp_q < tl_q);
    uw_c    = cfg_i.autoscale && (smp_q > th_q);
    if (cfg_i.autoscale) begin
      v_d = smp_q;
    end else if (smp_q < tl_q) begin
      v_d = tl_q;
    end else if (smp_q > th_q) begin
      v_d = th_q;
    end else begin
      v_d = smp_q;
    end
  end

  always_comb begin
    last_d = last_q;
    tl_d   = tl_q;
    th_d   = th_q;
    if (bload_i.low_we) begin
      tl_d = bload_i.value;
    end
    if (bload_i.high_we) begin
      th_d = bload_i.value;
    end
    if (do_test && take_c) begin
      last_d = smp_q;
      if (lw_c) begin
        tl_d = smp_q;
      end
      if (uw_c) begin
        th_d = smp_q;
      end
    end
  end

  // scaling: numerator times one hundred as shifted adds
  assign num      = v_q - tl_q;
  assign den      = th_q - tl_q;
  assign dividend = {1'b0, num, 6'b0} + {2'b0, num, 5'b0} + {5'b0, num, 2'b0};

  assign div_req_o.start    = div_start;
  assign div_req_o.dividend = dividend;
  assign div_req_o.divisor  = den;

  always_comb begin
    m_d = m_q;
    if (do_scale) begin
      // empty range maps to zero, reversed range to the clamped end
      m_d = (tl_q != th_q && v_q == th_q) ? lsps_pkg::PercentMax : lsps_pkg::PercentMin;
    end else if (div_rsp_i.done) begin
      m_d = div_rsp_i.quotient;
    end
  end

  // percent limits and result
  always_comb begin
    fl = lsps_pkg::sat_pct(cfg_i.pct_floor);
    ce = lsps_pkg::sat_pct(cfg_i.pct_ceil);
    if (m_q < fl) begin
      pct_c = fl;
    end else if (m_q > ce) begin
      pct_c = ce;
    end else begin
      pct_c = m_q;
    end
    held_d = held_q;
    if (fin_load && take_q) begin
      held_d = pct_c;
    end
    out_d               = out_q;
    out_valid_d         = out_valid_q && !out_ready_i;
    if (fin_load) begin
      out_valid_d         = 1'b1;
      out_d.percent       = take_q ? pct_c : held_q;
      out_d.accepted      = take_q;
      out_d.lower_widened = lw_q;
      out_d.upper_widened = uw_q;
      out_d.bound_low     = tl_q;
      out_d.bound_high    = th_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsps_pkg::ST_IDLE;
      last_q      <= lsps_pkg::ZeroSample;
      held_q      <= lsps_pkg::PercentMin;
      tl_q        <= lsps_pkg::ZeroSample;
      th_q        <= lsps_pkg::FullScale;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      held_q      <= held_d;
      tl_q        <= tl_d;
      th_q        <= th_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= cfg_i.invert ? lsps_pkg::FullScale - in_sample_i : in_sample_i;
    end
    if (do_test) begin
      take_q <= take_c;
      lw_q   <= take_c && lw_c;
      uw_q   <= take_c && uw_c;
      v_q    <= v_d;
    end
    m_q   <= m_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ hw/rtl/light_sensor_percent_scaler_core.sv @@
// top level of the light sensor percent scaler
`timescale 1ns / 1ps

// usage
//   sample_ch takes one 10-bit sample per item; result_ch gives one result item
//   per sample with the percent, the accept flag, the widen flags and the
//   tracked bounds after that sample.
//   the config port writes a register at every clock edge with cfg_we_i high;
//   range_low and range_high writes load the tracked bounds. write only while
//   no item is in flight.
// sequence
//   an accepted sample that passes the hysteresis test and has a normal range
//   goes through the test, scale and divide states and then loads the result
//   register; only then can the next sample be taken. the 7-step restoring
//   divider forms the percent. a rejected sample skips the scale and divide
//   states, an empty or reversed range skips the divide state.
// reset and stalls
//   reset loads the register defaults, clears the last sample and the held
//   percent and sets the tracked bounds to 0 and 1023.
//   a result waits in the output register while the receiver stalls; the next
//   sample is still taken and is held in its last step until the register
//   frees up.
module light_sensor_percent_scaler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lsps_stream_if.sink                   sample_ch,
  lsps_stream_if.source                 result_ch,
  input  logic                          cfg_we_i,
  input  logic [lsps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lsps_pkg::SampleW-1:0]  cfg_data_i
);

  lsps_pkg::cfg_t        cfg;
  lsps_pkg::bound_load_t bload;
  lsps_pkg::div_req_t    div_req;
  lsps_pkg::div_rsp_t    div_rsp;
  lsps_pkg::in_item_t    in_item;
  lsps_pkg::out_item_t   out_item;

  assign in_item = sample_ch.data;

  lsps_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .bload_o    (bload)
  );

  lsps_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lsps_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .bload_i     (bload),
    .in_valid_i  (sample_ch.valid),
    .in_ready_o  (sample_ch.ready),
    .in_sample_i (in_item.sample),
    .out_valid_o (result_ch.valid),
    .out_ready_i (result_ch.ready),
    .out_item_o  (out_item),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  assign result_ch.data = out_item;

endmodule

@@ hw/rtl/lsps_checker.sv @@
// port-level checks of the light sensor percent scaler and their binding
`timescale 1ns / 1ps

module lsps_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input lsps_pkg::out_item_t  out_item_i
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in work");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_item_i.percent <= lsps_pkg::PercentMax)
    else $error("percent above full scale");

  a_reject_no_widen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.accepted |->
      !out_item_i.lower_widened && !out_item_i.upper_widened)
    else $error("rejected item widened a bound");

  a_widen_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.lower_widened || out_item_i.upper_widened) |->
      out_item_i.bound_low <= out_item_i.bound_high)
    else $error("widened bounds out of order");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result changed");

endmodule

bind light_sensor_percent_scaler_core lsps_checker u_lsps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_ch.valid),
  .in_ready_i  (sample_ch.ready),
  .out_valid_i (result_ch.valid),
  .out_ready_i (result_ch.ready),
  .out_item_i  (result_ch.data)
);
